/* rtl/dtbox_pkg.sv */
package dtbox_pkg;

	// default size of the per-class threshold table
	localparam int MAX_CLASSES_DEF = 128;

	// hard cap on classes per detection, set by the 7-bit class fields
	localparam int CLASS_CAP = 128;

	// command codes on the input stream
	localparam logic [1:0] CMD_THR_WRITE = 2'd0;
	localparam logic [1:0] CMD_SCORE     = 2'd1;
	localparam logic [1:0] CMD_BOX       = 2'd2;

	// register indexes, byte address is four times the index
	localparam logic [1:0] REG_CLS_TOTAL  = 2'd0;
	localparam logic [1:0] REG_NET_WIDTH  = 2'd1;
	localparam logic [1:0] REG_NET_HEIGHT = 2'd2;

	// reset values of the registers
	localparam logic [7:0]  CLS_TOTAL_RST  = 8'd87;
	localparam logic [12:0] NET_WIDTH_RST  = 13'd640;
	localparam logic [12:0] NET_HEIGHT_RST = 13'd640;

	// queue depth between front and back
	localparam int QUEUE_DEPTH = 4;

	// operations carried through the queue
	typedef enum logic {
		OP_THR_WRITE = 1'b0,
		OP_BOX       = 1'b1
	} op_t;

	// register values seen by front and back
	typedef struct packed {
		logic [7:0]  cls_total;
		logic [12:0] net_width;
		logic [12:0] net_height;
	} cfg_t;

	// one queue entry: a threshold write or a finished detection
	typedef struct packed {
		op_t         op;
		logic [6:0]  cls;
		logic [15:0] val;
		logic        best_valid;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] w;
		logic [15:0] h;
	} entry_t;

endpackage

/* rtl/dtbox_ram.sv */
module dtbox_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/dtbox_queue.sv */
module dtbox_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dtbox_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output dtbox_pkg::entry_t head
);

	localparam int DEPTH = dtbox_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	dtbox_pkg::entry_t slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// no overflow, no underflow
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CW'(DEPTH)))
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue popped while empty");

endmodule

/* rtl/dtbox_front.sv */
module dtbox_front #(
	parameter int MAX_CLASSES = dtbox_pkg::MAX_CLASSES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dtbox_pkg::cfg_t   cfg,
	input  logic              in_valid,
	input  logic [1:0]        in_command,
	input  logic [86:0]       in_data,
	input  logic              queue_full,
	output logic              in_ready,
	output logic              push,
	output dtbox_pkg::entry_t push_entry
);

	localparam int TBL_DEPTH =
		(MAX_CLASSES < dtbox_pkg::CLASS_CAP) ? MAX_CLASSES : dtbox_pkg::CLASS_CAP;
	localparam logic [7:0] LIMIT_CAP = 8'(TBL_DEPTH);

	logic [6:0]  class_index;
	logic [15:0] value;
	logic        take;
	logic [7:0]  limit;
	logic        score_take;

	logic [15:0] best_score_q;
	logic [6:0]  best_class_q;
	logic        best_valid_q;
	logic [7:0]  class_cnt_q;

	assign class_index = in_data[6:0];
	assign value       = in_data[22:7];

	assign in_ready = !queue_full;
	assign take     = in_valid && in_ready;

	// class limit for this detection
	assign limit      = (cfg.cls_total < LIMIT_CAP) ? cfg.cls_total : LIMIT_CAP;
	assign score_take = take && (in_command == dtbox_pkg::CMD_SCORE) && (class_cnt_q < limit);

	// threshold writes inside the table and every box item go to the back
	always_comb begin
		push                  = 1'b0;
		push_entry.op         = dtbox_pkg::OP_BOX;
		push_entry.cls        = best_class_q;
		push_entry.val        = best_score_q;
		push_entry.best_valid = best_valid_q;
		push_entry.cx         = in_data[38:23];
		push_entry.cy         = in_data[54:39];
		push_entry.w          = in_data[70:55];
		push_entry.h          = in_data[86:71];
		case (in_command)
			dtbox_pkg::CMD_THR_WRITE: begin
				push           = take && ({1'b0, class_index} < LIMIT_CAP);
				push_entry.op  = dtbox_pkg::OP_THR_WRITE;
				push_entry.cls = class_index;
				push_entry.val = value;
			end
			dtbox_pkg::CMD_BOX: begin
				push = take;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// running argmax, strictly greater, cleared by each box item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_class_q <= '0;
			best_valid_q <= 1'b0;
			class_cnt_q  <= '0;
		end else if (take && (in_command == dtbox_pkg::CMD_BOX)) begin
			best_score_q <= '0;
			best_class_q <= '0;
			best_valid_q <= 1'b0;
			class_cnt_q  <= '0;
		end else if (score_take) begin
			if (value > best_score_q) begin
				best_score_q <= value;
				best_class_q <= class_cnt_q[6:0];
				best_valid_q <= 1'b1;
			end
			class_cnt_q <= class_cnt_q + 1'b1;
		end
	end

	// the counter never passes the table size, the best class stays below the count
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		class_cnt_q <= LIMIT_CAP)
		else $error("class counter past table size");

	a_best_below_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		best_valid_q |-> ({1'b0, best_class_q} < class_cnt_q))
		else $error("best class not yet counted");

endmodule

/* rtl/dtbox_back.sv */
module dtbox_back #(
	parameter int MAX_CLASSES = dtbox_pkg::MAX_CLASSES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dtbox_pkg::cfg_t   cfg,
	input  logic              head_valid,
	input  dtbox_pkg::entry_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [95:0]       out_data
);

	localparam int TBL_DEPTH =
		(MAX_CLASSES < dtbox_pkg::CLASS_CAP) ? MAX_CLASSES : dtbox_pkg::CLASS_CAP;
	localparam int AW = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	logic              en;
	logic              thr_we;
	logic [AW-1:0]     taddr;
	logic [15:0]       thr_rdata;
	logic [TBL_DEPTH-1:0] tvld_q;

	// stage 1: entry popped, threshold read under way
	logic              v_s1;
	logic [6:0]        cls_s1;
	logic [15:0]       score_s1;
	logic              bv_s1;
	logic              tv_s1;
	logic [15:0]       cx_s1, cy_s1, w_s1, h_s1;

	// stage 2: pass decision and products
	logic              v_s2;
	logic [6:0]        cls_s2;
	logic [15:0]       score_s2;
	logic signed [31:0] lprod_s2, tprod_s2;
	logic [28:0]       wprod_s2, hprod_s2;

	// stage 3: rounded edges and extents
	logic              v_s3;
	logic [6:0]        cls_s3;
	logic [15:0]       score_s3;
	logic signed [18:0] left_s3, top_s3;
	logic [17:0]       wsc_s3, hsc_s3;

	// output register
	logic              out_valid_q;
	logic [95:0]       out_data_q;

	logic [15:0]       thr_eff;
	logic              pass;
	logic signed [17:0] ldiff, tdiff;
	logic signed [31:0] lsum, tsum;
	logic [29:0]       wsum, hsum;
	logic signed [19:0] wroom, hroom, wr, hr;
	logic [16:0]       wout, hout;

	// whole back end moves unless a result waits untaken
	assign en  = !(out_valid_q && !out_ready);
	assign pop = en && head_valid;

	assign thr_we = pop && (head.op == dtbox_pkg::OP_THR_WRITE);
	assign taddr  = head.cls[AW-1:0];

	dtbox_ram #(
		.WIDTH(16),
		.DEPTH(TBL_DEPTH)
	) u_thr_ram (
		.clk   (clk),
		.we    (thr_we),
		.waddr (taddr),
		.wdata (head.val),
		.re    (en),
		.raddr (taddr),
		.rdata (thr_rdata)
	);

	// written marks, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvld_q <= '0;
			tv_s1  <= 1'b0;
		end else begin
			if (thr_we) begin
				tvld_q[taddr] <= 1'b1;
			end
			if (en) begin
				tv_s1 <= tvld_q[taddr];
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= pop && (head.op == dtbox_pkg::OP_BOX);
			v_s2        <= v_s1 && pass;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// threshold test and scaling products
	assign thr_eff = tv_s1 ? thr_rdata : 16'd0;
	assign pass    = bv_s1 && (score_s1 > thr_eff);
	assign ldiff   = $signed({1'b0, cx_s1, 1'b0}) - $signed({2'b00, w_s1});
	assign tdiff   = $signed({1'b0, cy_s1, 1'b0}) - $signed({2'b00, h_s1});

	// edge rounding, ties up, and extent rounding
	assign lsum = lprod_s2 + 32'sd4096;
	assign tsum = tprod_s2 + 32'sd4096;
	assign wsum = {1'b0, wprod_s2} + 30'd2048;
	assign hsum = {1'b0, hprod_s2} + 30'd2048;

	// room left to the right and bottom edges, then clamp
	assign wroom = $signed({3'b000, cfg.net_width, 4'b0000}) - 20'(left_s3);
	assign hroom = $signed({3'b000, cfg.net_height, 4'b0000}) - 20'(top_s3);
	assign wr    = ($signed({2'b00, wsc_s3}) < wroom) ? $signed({2'b00, wsc_s3}) : wroom;
	assign hr    = ($signed({2'b00, hsc_s3}) < hroom) ? $signed({2'b00, hsc_s3}) : hroom;
	assign wout  = wr[19] ? 17'd0 : wr[16:0];
	assign hout  = hr[19] ? 17'd0 : hr[16:0];

	// payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1   <= head.cls;
			score_s1 <= head.val;
			bv_s1    <= head.best_valid;
			cx_s1    <= head.cx;
			cy_s1    <= head.cy;
			w_s1     <= head.w;
			h_s1     <= head.h;

			cls_s2   <= cls_s1;
			score_s2 <= score_s1;
			lprod_s2 <= 32'(ldiff * $signed({1'b0, cfg.net_width}));
			tprod_s2 <= 32'(tdiff * $signed({1'b0, cfg.net_height}));
			wprod_s2 <= w_s1 * cfg.net_width;
			hprod_s2 <= h_s1 * cfg.net_height;

			cls_s3   <= cls_s2;
			score_s3 <= score_s2;
			left_s3  <= lsum[31:13];
			top_s3   <= tsum[31:13];
			wsc_s3   <= wsum[29:12];
			hsc_s3   <= hsum[29:12];

			out_data_q <= {3'b000, hout, wout, top_s3[17:0], left_s3[17:0],
				score_s3, cls_s3};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a stalled pipeline loses nothing
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en) |=> v_s3)
		else $error("stage three dropped under stall");

	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> !pop)
		else $error("entry popped while output stalled");

endmodule

/* rtl/detection_argmax_threshold_box_core.sv */
// Detection post-processing core. The input stream carries three commands in tuser:
// threshold write, class score and box; scores feed a running argmax (strictly greater,
// starting from zero) and each box item ends the detection and, when the best score beats
// that class's threshold, yields one result with the box in top-left pixel form (4 fraction
// bits, extent clamped to the network edge). The input takes one item per cycle while the
// queue has room: the front end's argmax compare runs once per cycle, and threshold writes
// and boxes pass a four-entry queue into a four-stage back end that does one table read and
// the scaling multiplies per cycle while the output is not stalled; a box item that passes
// goes through the queue, stages 1 to 3 and the output register before m_tvalid rises. The
// threshold table is a RAM with a written flag per entry, so it reads as zero after reset
// without any clearing pass. Registers: cls_total (scores per detection) at 0x0, net_width
// at 0x4, net_height at 0x8; write them only while the core is idle.
module detection_argmax_threshold_box_core #(
	parameter int MAX_CLASSES = dtbox_pkg::MAX_CLASSES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata from bit 0: class_index[7], value[16], box_cx[16], box_cy[16], box_w[16],
	// box_h[16], one zero pad bit
	input  logic [87:0] s_tdata,
	// tuser: command[2]
	input  logic [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata from bit 0: obj_class[7], confidence[16], left_px[18], top_px[18],
	// width_px[17], height_px[17], three zero pad bits
	output logic [95:0] m_tdata
);

	dtbox_pkg::cfg_t   cfg_q;
	logic              cfg_wr;
	logic              q_push;
	dtbox_pkg::entry_t q_push_entry;
	logic              q_full;
	logic              q_pop;
	logic              q_head_valid;
	dtbox_pkg::entry_t q_head;

	// register writes, byte lanes ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cls_total  <= dtbox_pkg::CLS_TOTAL_RST;
			cfg_q.net_width  <= dtbox_pkg::NET_WIDTH_RST;
			cfg_q.net_height <= dtbox_pkg::NET_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				dtbox_pkg::REG_CLS_TOTAL:  cfg_q.cls_total  <= pwdata[7:0];
				dtbox_pkg::REG_NET_WIDTH:  cfg_q.net_width  <= pwdata[12:0];
				dtbox_pkg::REG_NET_HEIGHT: cfg_q.net_height <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[3:2])
			dtbox_pkg::REG_CLS_TOTAL:  prdata = {24'd0, cfg_q.cls_total};
			dtbox_pkg::REG_NET_WIDTH:  prdata = {19'd0, cfg_q.net_width};
			dtbox_pkg::REG_NET_HEIGHT: prdata = {19'd0, cfg_q.net_height};
			default:                   prdata = 32'd0;
		endcase
	end

	dtbox_front #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_command (s_tuser),
		.in_data    (s_tdata[86:0]),
		.queue_full (q_full),
		.in_ready   (s_tready),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	dtbox_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	dtbox_back #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

	// the queue is never pushed past full from the input side
	a_push_ready: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (s_tvalid && s_tready))
		else $error("queue push without accepted item");

	// the pad bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[95:93] == 3'b000))
		else $error("result pad bits set");

	// back end pops only what the queue holds
	a_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("pop with queue empty");

endmodule

/* tb/sv/detection_argmax_threshold_box_core_test.sv */
module detection_argmax_threshold_box_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dtbox_pkg::*;

	// tuser code that the core must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 16;

	// input item as carried in s_tdata, class_index in the lowest bits
	typedef struct packed {
		logic        pad;
		logic [15:0] box_h;
		logic [15:0] box_w;
		logic [15:0] box_cy;
		logic [15:0] box_cx;
		logic [15:0] value;
		logic [6:0]  class_index;
	} det_in_t;

	// result item as carried in m_tdata, obj_class in the lowest bits
	typedef struct packed {
		logic [2:0]  pad;
		logic [16:0] height_px;
		logic [16:0] width_px;
		logic [17:0] top_px;
		logic [17:0] left_px;
		logic [15:0] confidence;
		logic [6:0]  obj_class;
	} det_out_t;

	// mirror of the core: threshold table, running argmax and box scaling
	class detection_board;
		logic [15:0] thr_mem [CLASS_CAP];
		logic [15:0] best_score;
		logic [6:0]  best_class;
		bit          best_valid;
		int unsigned score_count;
		logic [7:0]  cls_total;
		logic [12:0] net_width;
		logic [12:0] net_height;
		det_out_t    due_boxes [$];
		int          errors;

		function new();
			foreach (thr_mem[i])
				thr_mem[i] = '0;
			cls_total = CLS_TOTAL_RST;
			net_width = NET_WIDTH_RST;
			net_height = NET_HEIGHT_RST;
			errors = 0;
			end_detection();
		endfunction

		function void end_detection();
			best_score = '0;
			best_class = '0;
			best_valid = 0;
			score_count = 0;
		endfunction

		function void set_reg(logic [1:0] index, logic [31:0] value);
			case (index)
				REG_CLS_TOTAL:  cls_total = value[7:0];
				REG_NET_WIDTH:  net_width = value[12:0];
				REG_NET_HEIGHT: net_height = value[12:0];
				default: ;
			endcase
		endfunction

		// top-left edge: round((2c - s) * n / 2^13), ties upward
		function longint edge_px(logic [15:0] c, logic [15:0] s, logic [12:0] n);
			longint num;
			num = (2 * longint'(c) - longint'(s)) * longint'(n) + 4096;
			return num >>> 13;
		endfunction

		// extent clamped to the room left before the far edge, never negative
		function longint extent_px(logic [15:0] s, logic [12:0] n, longint e);
			longint scaled;
			longint room;
			longint r;
			scaled = (longint'(s) * longint'(n) + 2048) >>> 12;
			room = longint'(n) * 16 - e;
			r = (scaled < room) ? scaled : room;
			return (r < 0) ? 0 : r;
		endfunction

		function void note_item(logic [1:0] cmd, det_in_t it);
			int unsigned lim;
			longint left;
			longint top;
			det_out_t res;
			case (cmd)
				CMD_THR_WRITE: thr_mem[it.class_index] = it.value;
				CMD_SCORE: begin
					lim = (cls_total > CLASS_CAP) ? CLASS_CAP : cls_total;
					if (score_count < lim) begin
						if (it.value > best_score) begin
							best_score = it.value;
							best_class = score_count[6:0];
							best_valid = 1;
						end
						score_count++;
					end
				end
				CMD_BOX: begin
					if (best_valid && best_score > thr_mem[best_class]) begin
						left = edge_px(it.box_cx, it.box_w, net_width);
						top = edge_px(it.box_cy, it.box_h, net_height);
						res = '0;
						res.obj_class = best_class;
						res.confidence = best_score;
						res.left_px = 18'(left);
						res.top_px = 18'(top);
						res.width_px = 17'(extent_px(it.box_w, net_width, left));
						res.height_px = 17'(extent_px(it.box_h, net_height, top));
						due_boxes.insert(due_boxes.size(), res);
					end
					end_detection();
				end
				default: ;
			endcase
		endfunction

		function bit field_bad(string name, longint want, longint got);
			if (want == got)
				return 0;
			if (errors < 10)
				$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
			return 1;
		endfunction

		function void check_result(det_out_t got);
			det_out_t want;
			bit bad;
			if (due_boxes.size() == 0) begin
				if (errors < 10)
					$display("%0t: result item with none expected: %h", $time, got);
				errors++;
				return;
			end
			want = due_boxes.pop_front();
			bad = field_bad("obj_class", want.obj_class, got.obj_class);
			bad |= field_bad("confidence", want.confidence, got.confidence);
			bad |= field_bad("left_px", want.left_px, got.left_px);
			bad |= field_bad("top_px", want.top_px, got.top_px);
			bad |= field_bad("width_px", want.width_px, got.width_px);
			bad |= field_bad("height_px", want.height_px, got.height_px);
			if (bad)
				errors++;
		endfunction

		function int pending();
			return due_boxes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	// from bit 0: class_index, value, box_cx, box_cy, box_w, box_h, pad
	logic [87:0] s_tdata;
	// command
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// from bit 0: obj_class, confidence, left_px, top_px, width_px, height_px, pad
	logic [95:0] m_tdata;

	detection_board board;
	int          cycles = 0;
	int          items_sent = 0;
	bit          sender_calm = 0;
	bit          sink_calm = 0;
	int unsigned cur_limit;

	detection_argmax_threshold_box_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("detection_argmax_threshold_box_core_test: done, errors");
			$finish;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		m_tready = sink_calm ? 1'b1 : ($urandom_range(99) >= 34);
	end

	// result check at the accepting edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(det_out_t'(m_tdata));
	end

	function automatic det_in_t rand_item();
		det_in_t it;
		it.pad = 1'b0;
		it.class_index = 7'($urandom);
		it.value = 16'($urandom);
		it.box_cx = 16'($urandom);
		it.box_cy = 16'($urandom);
		it.box_w = 16'($urandom);
		it.box_h = 16'($urandom);
		return it;
	endfunction

	// one item on the input stream, with random idle cycles ahead of it
	task automatic push_item(input logic [1:0] cmd, input det_in_t it);
		@(negedge clk);
		if (!sender_calm) begin
			while ($urandom_range(99) < 34) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = it;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_item(cmd, it);
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic send_thr(input logic [6:0] idx, input logic [15:0] val);
		det_in_t it;
		it = rand_item();
		it.class_index = idx;
		it.value = val;
		push_item(CMD_THR_WRITE, it);
	endtask

	task automatic send_score(input logic [15:0] val);
		det_in_t it;
		it = rand_item();
		it.value = val;
		push_item(CMD_SCORE, it);
	endtask

	task automatic send_box(input logic [15:0] cx, input logic [15:0] cy,
			input logic [15:0] w, input logic [15:0] h);
		det_in_t it;
		it = rand_item();
		it.box_cx = cx;
		it.box_cy = cy;
		it.box_w = w;
		it.box_h = h;
		push_item(CMD_BOX, it);
	endtask

	// hold the stream until every result is out, then let the queue settle
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup then access, register taken when pready is seen
	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {index, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		board.set_reg(index, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_config(input int nc, input int nw, input int nh);
		drain();
		write_reg(REG_CLS_TOTAL, 32'(nc));
		write_reg(REG_NET_WIDTH, 32'(nw));
		write_reg(REG_NET_HEIGHT, 32'(nh));
		cur_limit = (nc > CLASS_CAP) ? CLASS_CAP : nc;
	endtask

	function automatic logic [15:0] pick_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return 16'h0000;
		if (r < 16)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// one detection: optional threshold update, scores, maybe noise, then the box
	task automatic run_detection();
		int unsigned n;
		int unsigned r;
		det_in_t it;
		if ($urandom_range(99) < 20) begin
			if ($urandom_range(1))
				send_thr(7'($urandom_range(15)), pick_value());
			else
				send_thr(7'($urandom), pick_value());
		end
		r = $urandom_range(99);
		if (r < 10)
			n = cur_limit + $urandom_range(1, 3);
		else if (r < 15)
			n = cur_limit;
		else
			n = $urandom_range(0, (cur_limit < 12) ? cur_limit : 12);
		for (int i = 0; i < n; i++)
			send_score(pick_value());
		if ($urandom_range(99) < 3)
			push_item(CMD_UNUSED, rand_item());
		it = rand_item();
		if ($urandom_range(99) < 10) begin
			it.box_cx = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			it.box_cy = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			it.box_w = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			it.box_h = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		end
		push_item(CMD_BOX, it);
	endtask

	task automatic random_phase(input int nc, input int nw, input int nh, input int count,
			input bit pause_mid);
		int stop_at;
		int mid_at;
		bit paused;
		set_config(nc, nw, nh);
		stop_at = items_sent + count;
		mid_at = items_sent + count / 2;
		paused = 0;
		while (items_sent < stop_at) begin
			run_detection();
			if (pause_mid && !paused && items_sent >= mid_at) begin
				drain();
				paused = 1;
			end
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_THR_WRITE;
		cur_limit = CLS_TOTAL_RST;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// reset registers: table extremes, argmax ties, empty and all-zero detections
		send_thr(7'd0, 16'h1000);
		send_thr(7'd127, 16'hFFFF);
		send_score(16'hFFFF);
		send_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
		send_box(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_score(16'h0000);
		send_score(16'h0000);
		send_box(16'h4000, 16'h4000, 16'h2000, 16'h2000);
		push_item(CMD_UNUSED, rand_item());
		send_score(16'h0005);
		send_score(16'h0005);
		send_score(16'h0009);
		send_box(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
		// score equal to its threshold does not pass
		send_thr(7'd0, 16'h1234);
		send_score(16'h1234);
		send_box(16'h8000, 16'h8000, 16'h1000, 16'h1000);

		// one class only: the second score is excess
		set_config(1, 4096, 1);
		send_score(16'h4000);
		send_score(16'hFFFF);
		send_box(16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001);

		// zero class limit takes nothing, then zero network size with full limit
		set_config(0, 0, 0);
		send_score(16'hFFFF);
		send_box(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		set_config(255, 0, 0);
		send_score(16'h8000);
		send_box(16'h8000, 16'h8000, 16'h8000, 16'h8000);

		// random detections under several register settings
		random_phase(4, 640, 480, 210, 1);
		random_phase(128, 4096, 4096, 210, 0);
		random_phase(9, 8191, 1, 210, 0);
		sender_calm = 1;
		sink_calm = 1;
		random_phase(255, 1920, 1080, 210, 0);
		sender_calm = 0;
		sink_calm = 0;
		random_phase(2, $urandom_range(8191), $urandom_range(8191), 210, 0);
		random_phase(1, 1, 4096, 210, 0);

		drain();
		if (board.errors == 0 && board.pending() == 0)
			$display("detection_argmax_threshold_box_core_test: done, clean");
		else
			$display("detection_argmax_threshold_box_core_test: done, errors");
		$finish;
	end

endmodule
